// File: sv/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
// Depends on nothing; imported by the top level and its checker.
package qrs_pkg;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_DOUBLE  = 2'd1,
      KIND_TWO     = 2'd2,
      KIND_INVALID = 2'd3
   } root_kind_type;

   localparam int ROOT_WIDTH = 32;
   localparam int ROOT_FRAC_BITS = 16;

endpackage

// File: sv/qrs_sqrt_cell.sv
// One cell of the square root chain: settles one root bit per beat.
// Standalone; instantiated in a row by the top level.
module qrs_sqrt_cell #(
   parameter int RW = 33,
   parameter int TW = 34
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  logic            valid_i,
   input  logic [2*RW-1:0] rad_i,
   input  logic [RW:0]     rem_i,
   input  logic [RW-1:0]   root_i,
   input  logic [TW-1:0]   tag_i,
   output logic            valid_o,
   output logic [2*RW-1:0] rad_o,
   output logic [RW:0]     rem_o,
   output logic [RW-1:0]   root_o,
   output logic [TW-1:0]   tag_o
);
   logic            valid_ff;
   logic [2*RW-1:0] rad_ff, rad_in;
   logic [RW:0]     rem_ff, rem_in;
   logic [RW-1:0]   root_ff, root_in;
   logic [TW-1:0]   tag_ff;
   logic [RW+2:0]   rcat, trial, diff;
   logic            ge;

   always_comb begin
      rcat    = {rem_i, rad_i[2*RW-1 -: 2]};
      trial   = {1'b0, root_i, 2'b01};
      diff    = rcat - trial;
      ge      = (rcat >= trial);
      rem_in  = ge ? diff[RW:0] : rcat[RW:0];
      root_in = {root_i[RW-2:0], ge};
      rad_in  = {rad_i[2*RW-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         tag_ff  <= tag_i;
      end
   end

   assign valid_o = valid_ff;
   assign rad_o   = rad_ff;
   assign rem_o   = rem_ff;
   assign root_o  = root_ff;
   assign tag_o   = tag_ff;
endmodule

// File: sv/qrs_div_cell.sv
// One cell of the divider chain: one quotient bit per beat for both roots.
// Standalone; instantiated in a row by the top level.
module qrs_div_cell #(
   parameter int NW = 34,
   parameter int DNW = 17,
   parameter int TW = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                valid_i,
   input  logic [DNW-1:0]      den_i,
   input  logic [1:0][DNW-1:0] rem_i,
   input  logic [1:0][NW-1:0]  nq_i,
   input  logic [TW-1:0]       tag_i,
   output logic                valid_o,
   output logic [DNW-1:0]      den_o,
   output logic [1:0][DNW-1:0] rem_o,
   output logic [1:0][NW-1:0]  nq_o,
   output logic [TW-1:0]       tag_o
);
   logic                valid_ff;
   logic [DNW-1:0]      den_ff;
   logic [1:0][DNW-1:0] rem_ff, rem_in;
   logic [1:0][NW-1:0]  nq_ff, nq_in;
   logic [TW-1:0]       tag_ff;
   logic [DNW:0]        rcat, diff;
   logic                ge;

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         rcat      = {rem_i[l], nq_i[l][NW-1]};
         diff      = rcat - {1'b0, den_i};
         ge        = (rcat >= {1'b0, den_i});
         rem_in[l] = ge ? diff[DNW-1:0] : rcat[DNW-1:0];
         nq_in[l]  = {nq_i[l][NW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_i;
      end
      if (en) begin
         den_ff <= den_i;
         rem_ff <= rem_in;
         nq_ff  <= nq_in;
         tag_ff <= tag_i;
      end
   end

   assign valid_o = valid_ff;
   assign den_o   = den_ff;
   assign rem_o   = rem_ff;
   assign nq_o    = nq_ff;
   assign tag_o   = tag_ff;
endmodule

// File: sv/quadratic_root_solver_unit.sv
// Throughput: one beat per cycle while no result beat waits on rsp_tready;
// the square root chain (COEF_WIDTH+17 cells) and the divider chain
// (COEF_WIDTH+18 cells) settle one bit per cell and stall as one.
// Reset clears all valid flags; the pipeline is empty and ready after reset.
// Depends on qrs_pkg, qrs_sqrt_cell and qrs_div_cell.
module quadratic_root_solver_unit #(
   parameter int COEF_WIDTH = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // coef_a, coef_b, coef_c from bit 0 up, zero padded to whole bytes.
   input  logic [((3*COEF_WIDTH+7)/8)*8-1:0]      req_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // root_one, root_two from bit 0 up.
   output logic [2*qrs_pkg::ROOT_WIDTH-1:0]       rsp_tdata,
   // root_kind, saturated from bit 0 up.
   output logic [2:0]                             rsp_tuser
);
   import qrs_pkg::*;

   localparam int CW  = COEF_WIDTH;
   localparam int DW  = 2*CW + 1;
   localparam int RW  = CW + 17;
   localparam int NW  = CW + 18;
   localparam int DNW = CW + 1;
   localparam int MW  = (NW > 33) ? NW : 33;
   localparam int STW = 2 + 2*CW;
   localparam int DTW = 4;

   function automatic logic [ROOT_WIDTH:0] clip(input logic [NW-1:0] mag, input logic neg);
      logic [MW-1:0]         mx;
      logic                  sat;
      logic [ROOT_WIDTH-1:0] val;
      mx = MW'(mag);
      if (neg) begin
         sat = (|mx[MW-1:32]) || (mx[31] && (|mx[30:0]));
         val = sat ? 32'h8000_0000 : (32'd0 - mx[31:0]);
      end else begin
         sat = |mx[MW-1:31];
         val = sat ? 32'h7FFF_FFFF : mx[31:0];
      end
      return {sat, val};
   endfunction

   logic en;
   logic out_valid_ff;
   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   // Products.
   logic                 v1_ff;
   logic signed [CW-1:0] a1_ff, b1_ff;
   logic [2*CW-1:0]      bb1_ff, ac1_ff;
   logic signed [CW-1:0] ca, cb, cc;
   assign ca = req_tdata[CW-1:0];
   assign cb = req_tdata[2*CW-1:CW];
   assign cc = req_tdata[3*CW-1:2*CW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         a1_ff  <= ca;
         b1_ff  <= cb;
         bb1_ff <= (2*CW)'(cb) * (2*CW)'(cb);
         ac1_ff <= (2*CW)'(ca) * (2*CW)'(cc);
      end
   end

   // Discriminant and kind.
   logic                 v2_ff;
   logic signed [CW-1:0] a2_ff, b2_ff;
   logic [DW-1:0]        disc2_ff;
   root_kind_type        kind2_ff, kind2_in;
   logic [2*CW+1:0]      disc_s;

   always_comb begin
      disc_s = {2'b00, bb1_ff} - {ac1_ff, 2'b00};
      if (a1_ff == '0) begin
         kind2_in = KIND_INVALID;
      end else if (disc_s[2*CW+1]) begin
         kind2_in = KIND_NONE;
      end else if (disc_s == '0) begin
         kind2_in = KIND_DOUBLE;
      end else begin
         kind2_in = KIND_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         a2_ff    <= a1_ff;
         b2_ff    <= b1_ff;
         kind2_ff <= kind2_in;
         disc2_ff <= disc_s[2*CW+1] ? '0 : disc_s[DW-1:0];
      end
   end

   // Square root chain.
   logic            sv_w   [RW+1];
   logic [2*RW-1:0] srad_w [RW+1];
   logic [RW:0]     srem_w [RW+1];
   logic [RW-1:0]   sroot_w[RW+1];
   logic [STW-1:0]  stag_w [RW+1];

   assign sv_w[0]    = v2_ff;
   assign srad_w[0]  = {1'b0, disc2_ff, 32'd0};
   assign srem_w[0]  = '0;
   assign sroot_w[0] = '0;
   assign stag_w[0]  = {kind2_ff, a2_ff, b2_ff};

   for (genvar i = 0; i < RW; i++) begin : g_sqrt
      qrs_sqrt_cell #(.RW(RW), .TW(STW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (sv_w[i]),
         .rad_i   (srad_w[i]),
         .rem_i   (srem_w[i]),
         .root_i  (sroot_w[i]),
         .tag_i   (stag_w[i]),
         .valid_o (sv_w[i+1]),
         .rad_o   (srad_w[i+1]),
         .rem_o   (srem_w[i+1]),
         .root_o  (sroot_w[i+1]),
         .tag_o   (stag_w[i+1])
      );
   end

   // Numerators and denominator.
   logic [1:0]          kind_s;
   logic [CW-1:0]       a_s, b_s;
   logic [NW:0]         b_ext, bsh, s_ext, n1, n2, n1m, n2m;
   logic [CW:0]         a_ext, amag;
   logic                v3_ff;
   logic [1:0]          kind3_ff;
   logic                neg1_3_ff, neg2_3_ff;
   logic [1:0][NW-1:0]  m3_ff;
   logic [DNW-1:0]      den3_ff;

   always_comb begin
      {kind_s, a_s, b_s} = stag_w[RW];
      b_ext = {{(NW+1-CW){b_s[CW-1]}}, b_s};
      bsh   = (NW+1)'((0 - b_ext) << ROOT_FRAC_BITS);
      s_ext = {{(NW+1-RW){1'b0}}, sroot_w[RW]};
      n1    = bsh - s_ext;
      n2    = bsh + s_ext;
      n1m   = n1[NW] ? (0 - n1) : n1;
      n2m   = n2[NW] ? (0 - n2) : n2;
      a_ext = {a_s[CW-1], a_s};
      amag  = a_s[CW-1] ? (CW+1)'(0 - a_ext) : a_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= sv_w[RW];
      end
      if (en) begin
         kind3_ff  <= kind_s;
         neg1_3_ff <= n1[NW] ^ a_s[CW-1];
         neg2_3_ff <= n2[NW] ^ a_s[CW-1];
         m3_ff[0]  <= n1m[NW-1:0];
         m3_ff[1]  <= n2m[NW-1:0];
         den3_ff   <= {amag[CW-1:0], 1'b0};
      end
   end

   // Divider chain.
   logic                dv_w  [NW+1];
   logic [DNW-1:0]      dden_w[NW+1];
   logic [1:0][DNW-1:0] drem_w[NW+1];
   logic [1:0][NW-1:0]  dnq_w [NW+1];
   logic [DTW-1:0]      dtag_w[NW+1];

   assign dv_w[0]   = v3_ff;
   assign dden_w[0] = den3_ff;
   assign drem_w[0] = '0;
   assign dnq_w[0]  = m3_ff;
   assign dtag_w[0] = {kind3_ff, neg2_3_ff, neg1_3_ff};

   for (genvar i = 0; i < NW; i++) begin : g_div
      qrs_div_cell #(.NW(NW), .DNW(DNW), .TW(DTW)) u_cell (
         .clock   (clock),
         .reset   (reset),
         .en      (en),
         .valid_i (dv_w[i]),
         .den_i   (dden_w[i]),
         .rem_i   (drem_w[i]),
         .nq_i    (dnq_w[i]),
         .tag_i   (dtag_w[i]),
         .valid_o (dv_w[i+1]),
         .den_o   (dden_w[i+1]),
         .rem_o   (drem_w[i+1]),
         .nq_o    (dnq_w[i+1]),
         .tag_o   (dtag_w[i+1])
      );
   end

   // Clipping and output register.
   logic [ROOT_WIDTH:0]   c1, c2;
   root_kind_type         kind_f;
   logic [ROOT_WIDTH-1:0] r1_ff, r2_ff;
   logic [1:0]            kind_ff;
   logic                  sat_ff;

   always_comb begin
      kind_f = root_kind_type'(dtag_w[NW][3:2]);
      c1     = clip(dnq_w[NW][0], dtag_w[NW][0]);
      c2     = clip(dnq_w[NW][1], dtag_w[NW][1]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_w[NW];
      end
      if (en) begin
         kind_ff <= kind_f;
         if (kind_f == KIND_DOUBLE || kind_f == KIND_TWO) begin
            r1_ff  <= c1[ROOT_WIDTH-1:0];
            r2_ff  <= c2[ROOT_WIDTH-1:0];
            sat_ff <= c1[ROOT_WIDTH] | c2[ROOT_WIDTH];
         end else begin
            r1_ff  <= '0;
            r2_ff  <= '0;
            sat_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {r2_ff, r1_ff};
   assign rsp_tuser  = {sat_ff, kind_ff};
endmodule

// File: sv/qrs_checker.sv
// Port-level checks of the result channel of the quadratic root solver.
// Depends on qrs_pkg; bound to quadratic_root_solver_unit below.
module qrs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import qrs_pkg::*;

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result beat changed");

   a_no_root_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[1:0] == KIND_NONE || rsp_tuser[1:0] == KIND_INVALID)
      |-> rsp_tdata == '0 && !rsp_tuser[2])
      else $error("rootless beat carries data");

   a_double_equal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_DOUBLE |-> rsp_tdata[31:0] == rsp_tdata[63:32])
      else $error("double root differs");
endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
